// ===== hdl/srr_pkg.sv =====
// Shared types and constants of the selective-repeat receiver.
package srr_pkg;

   localparam int SEQ_BITS  = 3;
   localparam int DATA_BITS = 32;

   localparam logic KIND_ACK  = 1'b0;
   localparam logic KIND_DATA = 1'b1;

   typedef struct packed {
      logic wr_en;
      logic clr_en;
   } store_ctl_type;

endpackage

// ===== hdl/selective_repeat_receiver.sv =====
// Top level of the selective-repeat ARQ receiver: sequencer, output register.
//
//   channel | direction | ports                                   | handshake
//   --------+-----------+-----------------------------------------+----------------------
//   req     | in        | seq_num, checksum_ok, payload           | req_valid/req_ready
//   rsp     | out       | kind, ack_num, data_out, last           | rsp_valid/rsp_ready
//
// A request with a bad checksum is taken and causes nothing.
// A good request is reduced below SEQ_SPACE by repeated subtraction (none is
// needed when SEQ_SPACE >= 8), offset from the window base and placed in its
// ring slot before the acknowledgement is loaded, then the in-order payloads
// follow; all modulo work goes through one compare-and-subtract unit, one reduction per cycle.
// req_ready is high only while the sequencer is idle. Output stalls hold the
// sequencer in the acknowledge or delivery step; the output register lets the
// next request in while the final result still waits.
// Synchronous reset empties all slots and sets window base and head to zero.
module selective_repeat_receiver #(
   parameter int WINDOW       = 4,
   parameter int SEQ_SPACE    = 8,
   parameter int PAYLOAD_BITS = 32
) (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [srr_pkg::SEQ_BITS-1:0]     req_seq_num,
   input  logic                             req_checksum_ok,
   input  logic [srr_pkg::DATA_BITS-1:0]    req_payload,

   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_kind,
   output logic [srr_pkg::SEQ_BITS-1:0]     rsp_ack_num,
   output logic [srr_pkg::DATA_BITS-1:0]    rsp_data_out,
   output logic                             rsp_last
);

   localparam int IW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int BW  = $clog2(SEQ_SPACE);
   localparam int AS  = $clog2(2 * SEQ_SPACE);
   localparam int AWN = $clog2(2 * WINDOW);
   localparam int AT  = (AS > AWN) ? AS : AWN;
   localparam int AW  = (AT > srr_pkg::SEQ_BITS) ? AT : srr_pkg::SEQ_BITS;

   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;  // wait for a request
   localparam logic [2:0] S_RED  = 3'd1;  // reduce seq_num modulo SEQ_SPACE
   localparam logic [2:0] S_OFF  = 3'd2;  // offset from the window base
   localparam logic [2:0] S_PHY  = 3'd3;  // physical slot, buffer the payload
   localparam logic [2:0] S_ACK  = 3'd4;  // emit the acknowledgement
   localparam logic [2:0] S_DLV  = 3'd5;  // emit in-order deliveries

   logic [2:0]                    state_ff, state_in;
   logic [AW-1:0]                 acc_ff, acc_in;
   logic [srr_pkg::SEQ_BITS-1:0]  seq_ff, seq_in;
   logic [PAYLOAD_BITS-1:0]       pay_ff, pay_in;
   logic                          in_win_ff, in_win_in;
   logic                          at_base_ff, at_base_in;
   logic [BW-1:0]                 base_ff, base_in;
   logic [IW-1:0]                 head_ff, head_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_kind_ff, rsp_kind_in;
   logic [srr_pkg::SEQ_BITS-1:0]  rsp_ack_ff, rsp_ack_in;
   logic [srr_pkg::DATA_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic [AW-1:0]                 unit_m, unit_r;
   logic                          unit_ge;
   logic [IW-1:0]                 phys, head_next;
   logic [BW-1:0]                 base_next;
   logic                          out_free;

   srr_pkg::store_ctl_type        store_ctl;
   logic [PAYLOAD_BITS-1:0]       rd_data;
   logic [WINDOW-1:0]             filled;

   // the one modulo unit: modulus WINDOW while placing in the ring, else SEQ_SPACE
   assign unit_m = (state_ff == S_PHY) ? AW'(WINDOW) : AW'(SEQ_SPACE);

   srr_mod_unit #(.AW(AW)) u_mod (
      .a  (acc_ff),
      .m  (unit_m),
      .r  (unit_r),
      .ge (unit_ge)
   );

   srr_slot_store #(
      .WINDOW       (WINDOW),
      .PAYLOAD_BITS (PAYLOAD_BITS),
      .IW           (IW)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .ctl      (store_ctl),
      .wr_addr  (phys),
      .wr_data  (pay_ff),
      .clr_addr (head_ff),
      .rd_addr  (head_ff),
      .rd_data  (rd_data),
      .filled   (filled)
   );

   assign phys      = unit_r[IW-1:0];
   assign head_next = (head_ff == IW'(WINDOW - 1)) ? '0 : head_ff + 1'b1;
   assign base_next = (base_ff == BW'(SEQ_SPACE - 1)) ? '0 : base_ff + 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      seq_in       = seq_ff;
      pay_in       = pay_ff;
      in_win_in    = in_win_ff;
      at_base_in   = at_base_ff;
      base_in      = base_ff;
      head_in      = head_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_ack_in   = rsp_ack_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      store_ctl    = '0;

      case (state_ff)
         S_IDLE: begin
            // take the request; drop it at once on a bad checksum
            if (req_valid) begin
               seq_in = req_seq_num;
               acc_in = AW'(req_seq_num);
               pay_in = PAYLOAD_BITS'(req_payload);
               if (req_checksum_ok) begin
                  state_in = S_RED;
               end
            end
         end
         S_RED: begin
            // subtract SEQ_SPACE until below it, then bias by the base
            if (unit_ge) begin
               acc_in = unit_r;
            end else begin
               acc_in   = acc_ff + AW'(SEQ_SPACE) - AW'(base_ff);
               state_in = S_OFF;
            end
         end
         S_OFF: begin
            in_win_in  = (unit_r < AW'(WINDOW));
            at_base_in = (unit_r == '0);
            acc_in     = AW'(head_ff) + unit_r;
            state_in   = S_PHY;
         end
         S_PHY: begin
            // buffer only into an empty slot; a duplicate keeps its first word
            store_ctl.wr_en = in_win_ff && !filled[phys];
            state_in        = S_ACK;
         end
         S_ACK: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = srr_pkg::KIND_ACK;
               rsp_ack_in   = seq_ff;
               rsp_data_in  = '0;
               rsp_last_in  = !(in_win_ff && at_base_ff);
               state_in     = (in_win_ff && at_base_ff) ? S_DLV : S_IDLE;
            end
         end
         S_DLV: begin
            // deliver the head slot, free it and advance base and head
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_kind_in     = srr_pkg::KIND_DATA;
               rsp_ack_in      = '0;
               rsp_data_in     = srr_pkg::DATA_BITS'(rd_data);
               rsp_last_in     = (head_next == head_ff) || !filled[head_next];
               store_ctl.clr_en = 1'b1;
               head_in         = head_next;
               base_in         = base_next;
               if ((head_next == head_ff) || !filled[head_next]) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         base_ff      <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      seq_ff      <= seq_in;
      pay_ff      <= pay_in;
      in_win_ff   <= in_win_in;
      at_base_ff  <= at_base_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_ack_ff  <= rsp_ack_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_ack_num  = rsp_ack_ff;
   assign rsp_data_out = rsp_data_ff;
   assign rsp_last     = rsp_last_ff;

   // a delivery step always finds the head slot filled
   a_dlv_filled : assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DLV |-> filled[head_ff])
      else $error("delivery from an empty head slot");

   // window base and ring head stay inside their ranges
   a_base_range : assert property (@(posedge clock) disable iff (reset)
      (base_ff < BW'(SEQ_SPACE - 1)) || (base_ff == BW'(SEQ_SPACE - 1)))
      else $error("window base out of range");

   a_head_range : assert property (@(posedge clock) disable iff (reset)
      (head_ff < IW'(WINDOW - 1)) || (head_ff == IW'(WINDOW - 1)))
      else $error("ring head out of range");

   // a request with a bad checksum leaves the block ready
   a_drop : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_checksum_ok |=> req_ready)
      else $error("dropped request did not return to idle");

   // delivered results carry no acknowledgement number
   a_dlv_ack : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == srr_pkg::KIND_DATA) |-> (rsp_ack_num == '0))
      else $error("delivery with a nonzero acknowledgement number");

endmodule

// ===== hdl/srr_mod_unit.sv =====
// Shared compare-and-subtract unit used for every modulo reduction.
module srr_mod_unit #(
   parameter int AW = 4
) (
   input  logic [AW-1:0] a,
   input  logic [AW-1:0] m,
   output logic [AW-1:0] r,
   output logic          ge
);

   assign ge = (a >= m);
   assign r  = ge ? (a - m) : a;

endmodule

// ===== hdl/srr_slot_store.sv =====
// Circular slot store: payload words and per-slot filled flags.
module srr_slot_store #(
   parameter int WINDOW       = 4,
   parameter int PAYLOAD_BITS = 32,
   parameter int IW           = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  srr_pkg::store_ctl_type    ctl,
   input  logic [IW-1:0]             wr_addr,
   input  logic [PAYLOAD_BITS-1:0]   wr_data,
   input  logic [IW-1:0]             clr_addr,
   input  logic [IW-1:0]             rd_addr,
   output logic [PAYLOAD_BITS-1:0]   rd_data,
   output logic [WINDOW-1:0]         filled
);

   logic [PAYLOAD_BITS-1:0] slot_ff [WINDOW];
   logic [WINDOW-1:0]       filled_ff;
   logic [WINDOW-1:0]       filled_in;

   always_comb begin
      filled_in = filled_ff;
      if (ctl.wr_en) begin
         filled_in[wr_addr] = 1'b1;
      end
      if (ctl.clr_en) begin
         filled_in[clr_addr] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff <= '0;
      end else begin
         filled_ff <= filled_in;
      end
   end

   // payload words carry no reset; a slot is read only once filled
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         slot_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = slot_ff[rd_addr];
   assign filled  = filled_ff;

endmodule

// ===== sim/srr_rx_checker.sv =====
// Checker for the selective-repeat receiver: predicts acks and deliveries and compares them.
module srr_rx_checker #(
   parameter int WINDOW    = 4,
   parameter int SEQ_SPACE = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [srr_pkg::SEQ_BITS-1:0]  req_seq_num,
   input  logic                          req_checksum_ok,
   input  logic [srr_pkg::DATA_BITS-1:0] req_payload,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic                          rsp_kind,
   input  logic [srr_pkg::SEQ_BITS-1:0]  rsp_ack_num,
   input  logic [srr_pkg::DATA_BITS-1:0] rsp_data_out,
   input  logic                          rsp_last,
   output int                            error_count,
   output int                            owed_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic                          kind;
      logic [srr_pkg::SEQ_BITS-1:0]  ack_num;
      logic [srr_pkg::DATA_BITS-1:0] data;
      logic                          last;
   } rsp_item_type;

   rsp_item_type                  owed_rsp[$];
   int                            rx_base;
   bit                            slot_full[WINDOW];
   logic [srr_pkg::DATA_BITS-1:0] slot_word[WINDOW];
   int                            errs = 0;

   // Ack the packet, buffer it if its slot is free, deliver the run from the base.
   task automatic accept_packet(input logic [srr_pkg::SEQ_BITS-1:0] seq,
                                input logic [srr_pkg::DATA_BITS-1:0] word);
      int           offset;
      int           moved;
      int           i;
      rsp_item_type item;
      offset = (int'(seq) % SEQ_SPACE + SEQ_SPACE - rx_base) % SEQ_SPACE;
      item   = '{kind: srr_pkg::KIND_ACK, ack_num: seq, data: '0, last: 1'b0};
      moved  = 0;
      if (offset < WINDOW) begin
         if (!slot_full[offset]) begin
            slot_full[offset] = 1'b1;
            slot_word[offset] = word;
         end
         if (offset == 0) begin
            while (moved < WINDOW && slot_full[moved]) begin
               owed_rsp = {owed_rsp, item};
               item = '{kind: srr_pkg::KIND_DATA, ack_num: '0,
                        data: slot_word[moved], last: 1'b0};
               moved++;
            end
            for (i = 0; i < WINDOW; i++) begin
               if (i + moved < WINDOW) begin
                  slot_full[i] = slot_full[i + moved];
                  slot_word[i] = slot_word[i + moved];
               end else begin
                  slot_full[i] = 1'b0;
               end
            end
            rx_base = (rx_base + moved) % SEQ_SPACE;
         end
      end
      item.last = 1'b1;
      owed_rsp = {owed_rsp, item};
   endtask

   task automatic check_response();
      rsp_item_type want;
      if (owed_rsp.size() == 0) begin
         errs++;
         $error("response with nothing owed: kind %0d ack_num %0d data_out %h last %0d",
                rsp_kind, rsp_ack_num, rsp_data_out, rsp_last);
      end else begin
         want = owed_rsp.pop_front();
         if (rsp_kind !== want.kind) begin
            errs++;
            $error("kind: expected %0d, got %0d", want.kind, rsp_kind);
         end
         if (rsp_ack_num !== want.ack_num) begin
            errs++;
            $error("ack_num: expected %0d, got %0d", want.ack_num, rsp_ack_num);
         end
         if (rsp_data_out !== want.data) begin
            errs++;
            $error("data_out: expected %h, got %h", want.data, rsp_data_out);
         end
         if (rsp_last !== want.last) begin
            errs++;
            $error("last: expected %0d, got %0d", want.last, rsp_last);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rx_base = 0;
         foreach (slot_full[i]) slot_full[i] = 1'b0;
         owed_rsp.delete();
      end else begin
         if (req_valid && req_ready && req_checksum_ok)
            accept_packet(req_seq_num, req_payload);
         if (rsp_valid && rsp_ready)
            check_response();
      end
      error_count <= errs;
      owed_count  <= owed_rsp.size();
   end

endmodule

// ===== sim/selective_repeat_receiver_tb.sv =====
// Testbench top for the selective-repeat receiver: request stimulus, back-pressure and verdict.
module selective_repeat_receiver_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WINDOW         = 4;
   localparam int SEQ_SPACE      = 8;
   localparam int PACKET_TARGET  = 140;   // good-checksum requests to send in all
   localparam int SQUEEZE_FROM   = 50;
   localparam int DRAIN_FROM     = 85;
   localparam int CALM_FROM      = 115;
   localparam int SQUEEZE_CYCLES = 300;
   localparam int TAIL_CYCLES    = 20;
   localparam int WATCHDOG_LIMIT = 2000;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic [srr_pkg::SEQ_BITS-1:0]  req_seq_num;
   logic                          req_checksum_ok;
   logic [srr_pkg::DATA_BITS-1:0] req_payload;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic                          rsp_kind;
   logic [srr_pkg::SEQ_BITS-1:0]  rsp_ack_num;
   logic [srr_pkg::DATA_BITS-1:0] rsp_data_out;
   logic                          rsp_last;

   int error_count;
   int owed_count;

   // Cross-process flags: written with nonblocking assignments, seen by readers after the current edge.
   bit calm        = 1'b0;   // last part of the run: no idling on either side
   bit squeeze_ask = 1'b0;   // ask the response side for its long hold-off

   int good_sent    = 0;
   int req_taken    = 0;
   int acks_seen    = 0;
   int deliveries   = 0;
   int quiet_cycles = 0;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   selective_repeat_receiver #(
      .WINDOW      (WINDOW),
      .SEQ_SPACE   (SEQ_SPACE),
      .PAYLOAD_BITS(32)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_seq_num    (req_seq_num),
      .req_checksum_ok(req_checksum_ok),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_ack_num    (rsp_ack_num),
      .rsp_data_out   (rsp_data_out),
      .rsp_last       (rsp_last)
   );

   srr_rx_checker #(
      .WINDOW   (WINDOW),
      .SEQ_SPACE(SEQ_SPACE)
   ) rx_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_seq_num    (req_seq_num),
      .req_checksum_ok(req_checksum_ok),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_ack_num    (rsp_ack_num),
      .rsp_data_out   (rsp_data_out),
      .rsp_last       (rsp_last),
      .error_count    (error_count),
      .owed_count     (owed_count)
   );

   // Occasionally drop valid after a request goes in.
   task sender_gap();
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   // Offer one request and hold it until the block takes it. Valid is only ever
   // raised here, so a back-to-back request never sees valid dropped and re-raised.
   task send_packet(input logic [srr_pkg::SEQ_BITS-1:0]  seq,
                    input logic                          ok,
                    input logic [srr_pkg::DATA_BITS-1:0] word);
      req_valid       <= 1'b1;
      req_seq_num     <= seq;
      req_checksum_ok <= ok;
      req_payload     <= word;
      do @(posedge clock); while (!req_ready);
      if (ok)
         good_sent++;
      sender_gap();
   endtask

   // Hold the request side idle until every owed response has come back.
   // The count is registered and lags the accepting edge, hence do-while.
   task drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (owed_count != 0);
   endtask

   // Response side: random stalls, one long hold-off on request, none when calm.
   initial begin
      bit squeeze_done;
      squeeze_done = 1'b0;
      rsp_ready    = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (squeeze_ask && !squeeze_done) begin
            // Starve the output long enough for the block to back up and
            // drop req_ready while the sender keeps offering.
            squeeze_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (SQUEEZE_CYCLES) @(posedge clock);
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end
      end
   end

   // Request stimulus: directed walk through the window, then random rounds.
   initial begin
      logic [srr_pkg::SEQ_BITS-1:0] tx_base;
      logic [srr_pkg::SEQ_BITS-1:0] pending[WINDOW];
      int                           left;
      int                           pick;
      int                           k;
      logic                         ok;
      bit                           mid_drained;

      reset           = 1'b1;
      req_valid       = 1'b0;
      req_seq_num     = '0;
      req_checksum_ok = 1'b0;
      req_payload     = '0;
      mid_drained     = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part, window base starts at 0.
      send_packet(3'd0, 1'b0, 32'hFFFF_FFFF);  // bad checksum: nothing comes back
      send_packet(3'd0, 1'b1, 32'h0000_0000);  // at the base: ack and one delivery
      send_packet(3'd0, 1'b1, 32'h1234_5678);  // just behind the base: ack only
      send_packet(3'd5, 1'b1, 32'h5A5A_5A5A);  // one past the window end: ack only
      send_packet(3'd4, 1'b1, 32'hFFFF_FFFF);  // fill the window from the top down
      send_packet(3'd3, 1'b1, 32'hAAAA_AAAA);
      send_packet(3'd2, 1'b1, 32'h5555_5555);
      send_packet(3'd4, 1'b1, 32'h0000_0000);  // duplicate: first payload must stay
      send_packet(3'd1, 1'b1, 32'h8000_0001);  // base: ack plus four deliveries
      send_packet(3'd7, 1'b1, 32'h0F0F_0F0F);  // window now 5..0, wraps past 7
      send_packet(3'd0, 1'b1, 32'hF0F0_F0F0);
      send_packet(3'd6, 1'b1, 32'h00FF_00FF);
      send_packet(3'd5, 1'b0, 32'h1357_9BDF);  // base number but corrupted
      send_packet(3'd5, 1'b1, 32'h7FFF_FFFE);  // base again: flush across the wrap
      send_packet(3'd1, 1'b0, 32'h0000_0000);
      send_packet(3'd2, 1'b1, 32'hC3C3_C3C3);
      send_packet(3'd1, 1'b1, 32'h3C3C_3C3C);  // delivers two, base moves to 3
      send_packet(3'd6, 1'b1, 32'hFFFF_FFFF);  // top slot left filled going into random
      drain();
      tx_base = 3'd3;

      // Random rounds: a well-behaved sender covering its window in random
      // order, with corrupted copies that get resent, duplicates and stray noise.
      while (good_sent < PACKET_TARGET) begin
         for (k = 0; k < WINDOW; k++)
            pending[k] = tx_base + k[srr_pkg::SEQ_BITS-1:0];
         left = WINDOW;
         while (left > 0) begin
            if ($urandom_range(0, 11) == 0) begin
               send_packet(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), $urandom());
            end else begin
               pick = $urandom_range(0, left - 1);
               ok   = ($urandom_range(0, 7) != 0);
               send_packet(pending[pick], ok, $urandom());
               if (ok) begin
                  if ($urandom_range(0, 9) == 0)
                     send_packet(pending[pick], 1'b1, $urandom());
                  pending[pick] = pending[left - 1];
                  left--;
               end
            end
            if (good_sent >= SQUEEZE_FROM)
               squeeze_ask <= 1'b1;
            if (good_sent >= DRAIN_FROM && !mid_drained) begin
               mid_drained = 1'b1;
               drain();
            end
            if (good_sent >= CALM_FROM)
               calm <= 1'b1;
         end
         tx_base = tx_base + 3'(WINDOW);
      end

      // Wind down: wait for the owed responses, then let stray ones show up.
      drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("requests taken: %0d, %0d of them with a good checksum", req_taken, good_sent);
      $display("responses checked: %0d acks, %0d in-order deliveries, incl. stall and drains",
               acks_seen, deliveries);
      if (error_count == 0)
         $display("selective_repeat_receiver_tb: done, clean");
      else
         $display("selective_repeat_receiver_tb: done, errors");
      $finish;
   end

   // Count handshakes for the summary and trip the watchdog on a long silence.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (req_valid && req_ready)
            req_taken <= req_taken + 1;
         if (rsp_valid && rsp_ready && rsp_kind == srr_pkg::KIND_ACK)
            acks_seen <= acks_seen + 1;
         if (rsp_valid && rsp_ready && rsp_kind == srr_pkg::KIND_DATA)
            deliveries <= deliveries + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("selective_repeat_receiver_tb: done, errors");
         $finish;
      end
   end

endmodule
